// ===== rtl/core/swk_pkg.sv =====
// swk_pkg: shared types, constants and helper functions for the swerve wheel kinematics
`timescale 1ns / 1ps
package swk_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned DeadbandDef    = 1;

  // cordic gain compensation, 0.6072529350 in q.30
  localparam logic [29:0] KGain = 30'd652032874;

  // angles inside the datapath are in units of 2^-18 degree
  localparam logic signed [29:0] Deg180 = 30'sd47185920;
  localparam logic signed [29:0] Deg90  = 30'sd23592960;

  // speeds saturate at the largest positive q1.15 code
  localparam logic [14:0] SpeedMax = 15'h7fff;

  typedef logic signed [39:0] vel_t;
  typedef logic [35:0]        mag_t;
  typedef logic signed [16:0] ang_t;

  typedef enum logic [2:0] {
    REG_LF_OFFSET_X = 3'd0,
    REG_LF_OFFSET_Y = 3'd1,
    REG_LR_OFFSET_X = 3'd2,
    REG_LR_OFFSET_Y = 3'd3,
    REG_RF_OFFSET_X = 3'd4,
    REG_RF_OFFSET_Y = 3'd5,
    REG_RR_OFFSET_X = 3'd6,
    REG_RR_OFFSET_Y = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] drive_speed;
    logic signed [15:0] drive_heading;
    logic signed [15:0] turn_rate;
    logic signed [15:0] lf_now_angle;
    logic signed [15:0] lr_now_angle;
    logic signed [15:0] rf_now_angle;
    logic signed [15:0] rr_now_angle;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] lf_wheel_speed;
    logic signed [15:0] lr_wheel_speed;
    logic signed [15:0] rf_wheel_speed;
    logic signed [15:0] rr_wheel_speed;
    logic signed [15:0] lf_wheel_angle;
    logic signed [15:0] lr_wheel_angle;
    logic signed [15:0] rf_wheel_angle;
    logic signed [15:0] rr_wheel_angle;
    logic               angles_valid;
  } res_t;

  // wheel offsets, lane order lf, lr, rf, rr
  typedef struct packed {
    logic [3:0][15:0] ox;
    logic [3:0][15:0] oy;
  } offs_t;

  // side data that rides along with each command
  typedef struct packed {
    logic             db;
    logic [3:0][15:0] now;
  } side_t;

  // atan(2^-i) in 2^-18 degree units
  function automatic logic [23:0] atan_val(input int unsigned i);
    case (i)
      0:  return 24'd11796480;
      1:  return 24'd6963869;
      2:  return 24'd3679517;
      3:  return 24'd1867780;
      4:  return 24'd937515;
      5:  return 24'd469214;
      6:  return 24'd234664;
      7:  return 24'd117339;
      8:  return 24'd58671;
      9:  return 24'd29335;
      10: return 24'd14668;
      11: return 24'd7334;
      12: return 24'd3667;
      13: return 24'd1833;
      14: return 24'd917;
      15: return 24'd458;
      16: return 24'd229;
      17: return 24'd115;
      18: return 24'd57;
      19: return 24'd29;
      20: return 24'd14;
      21: return 24'd7;
      22: return 24'd4;
      23: return 24'd2;
      default: return 24'd0;
    endcase
  endfunction

  // absolute angle error after wrapping into (-180, 180] degrees
  function automatic logic [13:0] wrap_abs(input logic signed [17:0] e);
    logic signed [18:0] r;
    r = 19'(e);
    if (r < -19'sd46080) begin
      r = r + 19'sd69120;
    end else if (r < -19'sd23040) begin
      r = r + 19'sd46080;
    end else if (r < 19'sd0) begin
      r = r + 19'sd23040;
    end else if (r >= 19'sd46080) begin
      r = r - 19'sd46080;
    end else if (r >= 19'sd23040) begin
      r = r - 19'sd23040;
    end
    if (r > 19'sd11520) begin
      r = 19'sd23040 - r;
    end
    return r[13:0];
  endfunction

endpackage

// ===== rtl/core/swk_front.sv =====
// swk_front: command conditioning, sine/cosine cordic and wheel velocity pipeline
`timescale 1ns / 1ps
module swk_front #(
  parameter int unsigned CordicSteps = swk_pkg::CordicStepsDef,
  parameter int unsigned Deadband    = swk_pkg::DeadbandDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  swk_pkg::cmd_t   cmd_i,
  input  swk_pkg::offs_t  offs_i,
  output logic            valid_o,
  output swk_pkg::vel_t   vx_o [4],
  output swk_pkg::vel_t   vy_o [4],
  output swk_pkg::side_t  side_o
);
  import swk_pkg::*;

  localparam int unsigned N = CordicSteps;

  typedef struct packed {
    logic signed [13:0] s;
    logic signed [13:0] w;
    logic               neg;
    side_t              side;
  } fr_t;

  // input conditioning
  logic [16:0]        s_abs, h_abs, w_abs;
  logic signed [13:0] s_cl, w_cl;
  logic signed [17:0] a;
  logic               neg;
  logic signed [27:0] z0;
  fr_t                f0;

  always_comb begin
    s_abs = cmd_i.drive_speed[15]   ? 17'(-17'(cmd_i.drive_speed))   : 17'(cmd_i.drive_speed);
    h_abs = cmd_i.drive_heading[15] ? 17'(-17'(cmd_i.drive_heading)) : 17'(cmd_i.drive_heading);
    w_abs = cmd_i.turn_rate[15]     ? 17'(-17'(cmd_i.turn_rate))     : 17'(cmd_i.turn_rate);

    if (cmd_i.drive_speed > 16'sd4096) begin
      s_cl = 14'sd4096;
    end else if (cmd_i.drive_speed < -16'sd4096) begin
      s_cl = -14'sd4096;
    end else begin
      s_cl = cmd_i.drive_speed[13:0];
    end
    if (cmd_i.turn_rate > 16'sd4096) begin
      w_cl = 14'sd4096;
    end else if (cmd_i.turn_rate < -16'sd4096) begin
      w_cl = -14'sd4096;
    end else begin
      w_cl = cmd_i.turn_rate[13:0];
    end

    // reduce heading to [-180, 180) then fold into [-90, 90]
    a = 18'(cmd_i.drive_heading);
    if (a >= 18'sd23040) begin
      a = a - 18'sd23040;
    end else if (a <= -18'sd23040) begin
      a = a + 18'sd23040;
    end
    if (a < 18'sd0) begin
      a = a + 18'sd23040;
    end
    if (a >= 18'sd11520) begin
      a = a - 18'sd23040;
    end
    neg = 1'b0;
    if (a > 18'sd5760) begin
      a   = a - 18'sd11520;
      neg = 1'b1;
    end else if (a < -18'sd5760) begin
      a   = a + 18'sd11520;
      neg = 1'b1;
    end
    z0 = $signed({a[15:0], 12'd0});

    f0.s    = s_cl;
    f0.w    = w_cl;
    f0.neg  = neg;
    f0.side.db  = (s_abs < 17'(Deadband)) && (h_abs < 17'(Deadband)) &&
                  (w_abs < 17'(Deadband));
    f0.side.now = {cmd_i.rr_now_angle, cmd_i.rf_now_angle,
                   cmd_i.lr_now_angle, cmd_i.lf_now_angle};
  end

  // rotation-mode cordic, one micro-rotation per stage
  logic [N:0]         cv_q;
  logic signed [32:0] cx_q [N+1];
  logic signed [32:0] cy_q [N+1];
  logic signed [27:0] cz_q [N+1];
  fr_t                cf_q [N+1];

  always_ff @(posedge clk_i) begin
    cx_q[0] <= 33'sd652032874;
    cy_q[0] <= '0;
    cz_q[0] <= z0;
    cf_q[0] <= f0;
    for (int i = 0; i < N; i++) begin
      if (!cz_q[i][27]) begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - $signed({4'd0, atan_val(i)});
      end else begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + $signed({4'd0, atan_val(i)});
      end
      cf_q[i+1] <= cf_q[i];
    end
  end

  // body velocity and turn contribution products
  logic signed [32:0] sn, cs;
  logic signed [46:0] ps, pc;
  vel_t               vtx_d, vty_d;
  logic signed [29:0] wx_d [4];
  logic signed [29:0] wy_d [4];

  always_comb begin
    sn    = cf_q[N].neg ? -cy_q[N] : cy_q[N];
    cs    = cf_q[N].neg ? -cx_q[N] : cx_q[N];
    ps    = 47'(cf_q[N].s) * 47'(sn);
    pc    = 47'(cf_q[N].s) * 47'(cs);
    vtx_d = 40'((-ps) >>> 12);
    vty_d = 40'(pc >>> 12);
    for (int k = 0; k < 4; k++) begin
      wx_d[k] = 30'(cf_q[N].w) * 30'($signed(offs_i.ox[k]));
      wy_d[k] = 30'(cf_q[N].w) * 30'($signed(offs_i.oy[k]));
    end
  end

  logic               mv_q, av_q;
  vel_t               vtx_q, vty_q;
  logic signed [29:0] wx_q [4];
  logic signed [29:0] wy_q [4];
  side_t              ms_q, as_q;
  vel_t               vx_q [4];
  vel_t               vy_q [4];

  always_ff @(posedge clk_i) begin
    vtx_q <= vtx_d;
    vty_q <= vty_d;
    wx_q  <= wx_d;
    wy_q  <= wy_d;
    ms_q  <= cf_q[N].side;
    for (int k = 0; k < 4; k++) begin
      vx_q[k] <= vtx_q - (40'(wy_q[k]) <<< 6);
      vy_q[k] <= vty_q + (40'(wx_q[k]) <<< 6);
    end
    as_q <= ms_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
      mv_q <= 1'b0;
      av_q <= 1'b0;
    end else begin
      cv_q <= {cv_q[N-1:0], valid_i};
      mv_q <= cv_q[N];
      av_q <= mv_q;
    end
  end

  assign valid_o = av_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign side_o  = as_q;

endmodule

// ===== rtl/core/swk_polar.sv =====
// swk_polar: four-lane vectoring cordic giving wheel magnitude and angle
`timescale 1ns / 1ps
module swk_polar #(
  parameter int unsigned CordicSteps = swk_pkg::CordicStepsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  swk_pkg::vel_t  vx_i [4],
  input  swk_pkg::vel_t  vy_i [4],
  input  swk_pkg::side_t side_i,
  output logic           valid_o,
  output swk_pkg::mag_t  mag_o [4],
  output swk_pkg::ang_t  ang_o [4],
  output swk_pkg::side_t side_o
);
  import swk_pkg::*;

  localparam int unsigned N = CordicSteps;

  logic [N:0]         pv_q;
  logic signed [39:0] px_q [N+1][4];
  logic signed [39:0] py_q [N+1][4];
  logic signed [29:0] pz_q [N+1][4];
  side_t              ps_q [N+1];

  always_ff @(posedge clk_i) begin
    // left half plane: turn by 180 degrees first
    for (int k = 0; k < 4; k++) begin
      if (vx_i[k][39]) begin
        px_q[0][k] <= -vx_i[k];
        py_q[0][k] <= -vy_i[k];
        pz_q[0][k] <= vy_i[k][39] ? -Deg180 : Deg180;
      end else begin
        px_q[0][k] <= vx_i[k];
        py_q[0][k] <= vy_i[k];
        pz_q[0][k] <= '0;
      end
    end
    ps_q[0] <= side_i;
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (!py_q[i][k][39]) begin
          px_q[i+1][k] <= px_q[i][k] + (py_q[i][k] >>> i);
          py_q[i+1][k] <= py_q[i][k] - (px_q[i][k] >>> i);
          pz_q[i+1][k] <= pz_q[i][k] + $signed({6'd0, atan_val(i)});
        end else begin
          px_q[i+1][k] <= px_q[i][k] - (py_q[i][k] >>> i);
          py_q[i+1][k] <= py_q[i][k] + (px_q[i][k] >>> i);
          pz_q[i+1][k] <= pz_q[i][k] - $signed({6'd0, atan_val(i)});
        end
      end
      ps_q[i+1] <= ps_q[i];
    end
  end

  // gain compensation split into two partial products
  logic [44:0]        pl_d [4];
  logic [44:0]        ph_d [4];
  logic signed [29:0] zz [4];
  ang_t               an_d [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pl_d[k] = 45'(px_q[N][k][20:6]) * 45'(KGain);
      ph_d[k] = 45'(px_q[N][k][35:21]) * 45'(KGain);
      zz[k]   = pz_q[N][k] - Deg90 + 30'sd2048;
      an_d[k] = 17'(zz[k] >>> 12);
    end
  end

  logic        m1v_q, m2v_q;
  logic [44:0] pl_q [4];
  logic [44:0] ph_q [4];
  ang_t        a1_q [4];
  ang_t        a2_q [4];
  mag_t        mg_q [4];
  side_t       s1_q, s2_q;
  logic [59:0] msum [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      msum[k] = {ph_q[k], 15'd0} + {15'd0, pl_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    ph_q <= ph_d;
    a1_q <= an_d;
    s1_q <= ps_q[N];
    for (int k = 0; k < 4; k++) begin
      mg_q[k] <= msum[k][59:24];
    end
    a2_q <= a1_q;
    s2_q <= s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
    end else begin
      pv_q  <= {pv_q[N-1:0], valid_i};
      m1v_q <= pv_q[N];
      m2v_q <= m1v_q;
    end
  end

  assign valid_o = m2v_q;
  assign mag_o   = mg_q;
  assign ang_o   = a2_q;
  assign side_o  = s2_q;

endmodule

// ===== rtl/core/swk_scale.sv =====
// swk_scale: speed normalisation divider and flip selection
`timescale 1ns / 1ps
module swk_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  swk_pkg::mag_t  mag_i [4],
  input  swk_pkg::ang_t  ang_i [4],
  input  swk_pkg::side_t side_i,
  output logic           valid_o,
  output swk_pkg::res_t  res_o
);
  import swk_pkg::*;

  localparam int unsigned QBits  = 16;
  localparam int unsigned Stages = QBits + 4;

  logic [Stages-1:0] v_q;

  // rounded speed for the unscaled case
  logic [36:0] rsum [4];
  logic [14:0] rnd_d [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k]  = (37'(mag_i[k]) + 37'd16384) >> 15;
      rnd_d[k] = (rsum[k] > 37'd32767) ? SpeedMax : rsum[k][14:0];
    end
  end

  // first level of the maximum tree
  mag_t        m1_mag [4];
  ang_t        m1_ang [4];
  logic [14:0] m1_rnd [4];
  mag_t        m1_h01, m1_h23;
  side_t       m1_side;

  always_ff @(posedge clk_i) begin
    m1_mag  <= mag_i;
    m1_ang  <= ang_i;
    m1_rnd  <= rnd_d;
    m1_h01  <= (mag_i[0] > mag_i[1]) ? mag_i[0] : mag_i[1];
    m1_h23  <= (mag_i[2] > mag_i[3]) ? mag_i[2] : mag_i[3];
    m1_side <= side_i;
  end

  // restoring divider, one quotient bit per stage
  logic [36:0] d_r_q   [QBits+1][4];
  logic [15:0] d_q_q   [QBits+1][4];
  mag_t        d_top_q [QBits+1];
  ang_t        d_ang_q [QBits+1][4];
  logic [14:0] d_rnd_q [QBits+1][4];
  side_t       d_sd_q  [QBits+1];

  logic [36:0] t_d  [QBits][4];
  logic [36:0] r_d  [QBits][4];
  logic        qb_d [QBits][4];

  always_comb begin
    for (int j = 0; j < QBits; j++) begin
      for (int k = 0; k < 4; k++) begin
        t_d[j][k]  = (j == 0) ? d_r_q[j][k] : {d_r_q[j][k][35:0], 1'b0};
        qb_d[j][k] = (t_d[j][k] >= 37'(d_top_q[j]));
        r_d[j][k]  = qb_d[j][k] ? (t_d[j][k] - 37'(d_top_q[j])) : t_d[j][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      d_r_q[0][k]   <= 37'(m1_mag[k]);
      d_q_q[0][k]   <= '0;
      d_ang_q[0][k] <= m1_ang[k];
      d_rnd_q[0][k] <= m1_rnd[k];
    end
    d_top_q[0] <= (m1_h01 > m1_h23) ? m1_h01 : m1_h23;
    d_sd_q[0]  <= m1_side;
    for (int j = 0; j < QBits; j++) begin
      for (int k = 0; k < 4; k++) begin
        d_r_q[j+1][k]   <= r_d[j][k];
        d_q_q[j+1][k]   <= {d_q_q[j][k][14:0], qb_d[j][k]};
        d_ang_q[j+1][k] <= d_ang_q[j][k];
        d_rnd_q[j+1][k] <= d_rnd_q[j][k];
      end
      d_top_q[j+1] <= d_top_q[j];
      d_sd_q[j+1]  <= d_sd_q[j];
    end
  end

  // speed pick, alternate angle and wrapped errors
  logic               big;
  logic [14:0]        sp_d [4];
  logic signed [17:0] alt_d [4];
  logic [13:0]        e1_d [4];
  logic [13:0]        e2_d [4];

  always_comb begin
    big = d_top_q[QBits] > 36'd1073741824;
    for (int k = 0; k < 4; k++) begin
      if (big) begin
        sp_d[k] = d_q_q[QBits][k][15] ? SpeedMax : d_q_q[QBits][k][14:0];
      end else begin
        sp_d[k] = d_rnd_q[QBits][k];
      end
      if (18'(d_ang_q[QBits][k]) + 18'sd11520 > 18'sd23040) begin
        alt_d[k] = 18'(d_ang_q[QBits][k]) - 18'sd11520;
      end else begin
        alt_d[k] = 18'(d_ang_q[QBits][k]) + 18'sd11520;
      end
      e1_d[k] = wrap_abs(18'(d_ang_q[QBits][k]) -
                         18'($signed(d_sd_q[QBits].now[k])));
      e2_d[k] = wrap_abs(alt_d[k] - 18'($signed(d_sd_q[QBits].now[k])));
    end
  end

  logic [14:0]        f_sp  [4];
  ang_t               f_ang [4];
  logic signed [17:0] f_alt [4];
  logic [13:0]        f_e1  [4];
  logic [13:0]        f_e2  [4];
  side_t              f_sd;

  always_ff @(posedge clk_i) begin
    f_sp  <= sp_d;
    f_alt <= alt_d;
    f_e1  <= e1_d;
    f_e2  <= e2_d;
    f_sd  <= d_sd_q[QBits];
    for (int k = 0; k < 4; k++) begin
      f_ang[k] <= d_ang_q[QBits][k];
    end
  end

  // flip decision and deadband override
  logic signed [15:0] osp [4];
  logic signed [15:0] oan [4];
  res_t               res_d, res_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (f_sd.db) begin
        osp[k] = '0;
        oan[k] = $signed(f_sd.now[k]);
      end else if (f_e1[k] > f_e2[k]) begin
        osp[k] = -$signed({1'b0, f_sp[k]});
        oan[k] = f_alt[k][15:0];
      end else begin
        osp[k] = $signed({1'b0, f_sp[k]});
        oan[k] = f_ang[k][15:0];
      end
    end
    res_d.lf_wheel_speed = osp[0];
    res_d.lr_wheel_speed = osp[1];
    res_d.rf_wheel_speed = osp[2];
    res_d.rr_wheel_speed = osp[3];
    res_d.lf_wheel_angle = oan[0];
    res_d.lr_wheel_angle = oan[1];
    res_d.rf_wheel_angle = oan[2];
    res_d.rr_wheel_angle = oan[3];
    res_d.angles_valid   = !f_sd.db;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o = v_q[Stages-1];
  assign res_o   = res_q;

endmodule

// ===== rtl/core/swerve_drive_wheel_kinematics.sv =====
// swerve_drive_wheel_kinematics: top level of the swerve wheel kinematics pipeline
`timescale 1ns / 1ps
// A drive command (speed, heading, turn rate and the four present servo angles) is taken
// on every clock edge with start high; busy never rises, so a command may follow in the
// very next cycle. Each command gives exactly one result, shown on res_o for a single cycle
// with done_o high, after the two chains of cordic stages (sine/cosine, then four parallel
// vectoring lanes) and the 16-stage divider that rescales wheel speeds. The receiver cannot
// hold a result off, so it must sample res_o whenever done_o is high. The user must write
// wheel offsets through the cfg port only while no command is in flight; the block itself
// does not enforce this.
module swerve_drive_wheel_kinematics #(
  parameter int unsigned CORDIC_STEPS = swk_pkg::CordicStepsDef,
  parameter int unsigned DEADBAND     = swk_pkg::DeadbandDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  swk_pkg::cmd_t cmd_i,
  output logic          done_o,
  output swk_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import swk_pkg::*;

  localparam int unsigned Lat = 2 * CORDIC_STEPS + 26;

  // offset registers, lane order lf, lr, rf, rr
  offs_t offs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LF_OFFSET_X: offs_q.ox[0] <= cfg_data_i;
        REG_LF_OFFSET_Y: offs_q.oy[0] <= cfg_data_i;
        REG_LR_OFFSET_X: offs_q.ox[1] <= cfg_data_i;
        REG_LR_OFFSET_Y: offs_q.oy[1] <= cfg_data_i;
        REG_RF_OFFSET_X: offs_q.ox[2] <= cfg_data_i;
        REG_RF_OFFSET_Y: offs_q.oy[2] <= cfg_data_i;
        REG_RR_OFFSET_X: offs_q.ox[3] <= cfg_data_i;
        REG_RR_OFFSET_Y: offs_q.oy[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the pipeline never stalls, every start is a transfer
  assign busy = 1'b0;

  logic  fr_valid;
  vel_t  fr_vx [4];
  vel_t  fr_vy [4];
  side_t fr_side;

  swk_front #(
    .CordicSteps(CORDIC_STEPS),
    .Deadband   (DEADBAND)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start),
    .cmd_i  (cmd_i),
    .offs_i (offs_q),
    .valid_o(fr_valid),
    .vx_o   (fr_vx),
    .vy_o   (fr_vy),
    .side_o (fr_side)
  );

  logic  po_valid;
  mag_t  po_mag [4];
  ang_t  po_ang [4];
  side_t po_side;

  swk_polar #(
    .CordicSteps(CORDIC_STEPS)
  ) u_polar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(fr_valid),
    .vx_i   (fr_vx),
    .vy_i   (fr_vy),
    .side_i (fr_side),
    .valid_o(po_valid),
    .mag_o  (po_mag),
    .ang_o  (po_ang),
    .side_o (po_side)
  );

  // speed rescale by the largest magnitude and flip selection
  swk_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(po_valid),
    .mag_i  (po_mag),
    .ang_i  (po_ang),
    .side_i (po_side),
    .valid_o(done_o),
    .res_o  (res_o)
  );

  // every transfer is answered by a result with done_o high
  a_lat_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(Lat) done_o) else $error("result missing after transfer");

  a_lat_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##(Lat) !done_o) else $error("result without a transfer");

  // deadband results carry zero speeds
  a_db_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.angles_valid) |-> (res_o.lf_wheel_speed == 16'sd0 &&
      res_o.lr_wheel_speed == 16'sd0 && res_o.rf_wheel_speed == 16'sd0 &&
      res_o.rr_wheel_speed == 16'sd0)) else $error("deadband speed not zero");

  // saturation keeps speeds within plus or minus full scale
  a_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.lf_wheel_speed != -16'sd32768 &&
      res_o.lr_wheel_speed != -16'sd32768 && res_o.rf_wheel_speed != -16'sd32768 &&
      res_o.rr_wheel_speed != -16'sd32768)) else $error("speed saturation broken");

endmodule

// ===== bench/tb_swerve_drive_wheel_kinematics.sv =====
// testbench for the swerve wheel kinematics block, self-checking against a built-in predictor
`timescale 1ns / 1ps
module tb_swerve_drive_wheel_kinematics;
  import swk_pkg::*;

  localparam int CordicSteps = 16;
  localparam int Deadband    = 1;
  localparam int Latency     = 2 * CordicSteps + 26;
  localparam int StallLimit  = 2000;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 225;

  // predicts wheel speeds and angles for each command and checks the results in order
  class wheel_scoreboard;
    logic signed [15:0] off_x[4];
    logic signed [15:0] off_y[4];
    res_t               pending[$];
    int                 errors;
    longint             atan_q[24];

    function new();
      atan_q = '{11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
                 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
                 229, 115, 57, 29, 14, 7, 4, 2};
      errors = 0;
      foreach (off_x[k]) begin
        off_x[k] = '0;
        off_y[k] = '0;
      end
    endfunction

    function void set_offset(cfg_reg_e r, logic [15:0] v);
      // even index holds x, odd holds y; lanes lf, lr, rf, rr
      if (r[0]) off_y[r >> 1] = v;
      else      off_x[r >> 1] = v;
    endfunction

    // rotation-mode cordic: sine and cosine of a heading in 1/64 degree
    function void heading_sin_cos(int h, output longint sn, output longint cs);
      int     a;
      bit     folded;
      longint x, y, z, t;
      a = h % 23040;
      folded = 0;
      if (a < 0) a += 23040;
      if (a >= 11520) a -= 23040;
      if (a > 5760) begin
        a -= 11520;
        folded = 1;
      end else if (a < -5760) begin
        a += 11520;
        folded = 1;
      end
      x = 652032874;
      y = 0;
      z = longint'(a) * 4096;
      for (int i = 0; i < CordicSteps; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q[i];
        end
        x = t;
      end
      sn = folded ? -y : y;
      cs = folded ? -x : x;
    endfunction

    // vectoring-mode cordic: magnitude in q.30, angle minus 90 degrees in 1/64 degree
    function void wheel_polar(longint vx, longint vy, output longint mag, output int ang);
      longint x, y, z, t;
      x = vx;
      y = vy;
      z = 0;
      if (vx < 0) begin
        x = -vx;
        y = -vy;
        z = (vy >= 0) ? 180 * 262144 : -180 * 262144;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q[i];
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q[i];
        end
        x = t;
      end
      mag = ((x >>> 6) * 652032874) >>> 24;
      ang = int'((z - 90 * 262144 + 2048) >>> 12);
    endfunction

    // absolute angle error folded into (-180, 180] degrees
    function int angle_dist(int e);
      int m;
      m = e % 23040;
      if (m < 0) m += 23040;
      if (m > 11520) m -= 23040;
      return (m < 0) ? -m : m;
    endfunction

    function int clamp_unit(int v);
      if (v > 4096) return 4096;
      if (v < -4096) return -4096;
      return v;
    endfunction

    function void note_cmd(cmd_t c);
      res_t   r;
      int     s, h, w, alt;
      int     now[4], ang[4];
      longint mag[4], sn, cs, vtx, vty, top, sp;
      s = c.drive_speed;
      h = c.drive_heading;
      w = c.turn_rate;
      now = '{int'(c.lf_now_angle), int'(c.lr_now_angle),
              int'(c.rf_now_angle), int'(c.rr_now_angle)};
      if ((s < 0 ? -s : s) < Deadband && (h < 0 ? -h : h) < Deadband &&
          (w < 0 ? -w : w) < Deadband) begin
        // deadband: stop wheels, hold servos where they are
        r = '0;
        r.lf_wheel_angle = c.lf_now_angle;
        r.lr_wheel_angle = c.lr_now_angle;
        r.rf_wheel_angle = c.rf_now_angle;
        r.rr_wheel_angle = c.rr_now_angle;
        pending.push_back(r);
        return;
      end
      s = clamp_unit(s);
      w = clamp_unit(w);
      heading_sin_cos(h, sn, cs);
      vtx = (-(longint'(s) * sn)) >>> 12;
      vty = (longint'(s) * cs) >>> 12;
      top = 0;
      for (int k = 0; k < 4; k++) begin
        wheel_polar(vtx - longint'(w) * longint'(off_y[k]) * 64,
                    vty + longint'(w) * longint'(off_x[k]) * 64, mag[k], ang[k]);
        if (mag[k] > top) top = mag[k];
      end
      r = '0;
      r.angles_valid = 1'b1;
      for (int k = 0; k < 4; k++) begin
        // rescale only when some wheel would exceed full speed
        if (top > (longint'(1) << 30)) sp = (mag[k] * 32768) / top;
        else sp = (mag[k] + 16384) >>> 15;
        if (sp > 32767) sp = 32767;
        if (sp < 0) sp = 0;
        alt = (ang[k] + 11520 > 23040) ? ang[k] - 11520 : ang[k] + 11520;
        if (angle_dist(ang[k] - now[k]) > angle_dist(alt - now[k])) begin
          ang[k] = alt;
          sp = -sp;
        end
        case (k)
          0: begin r.lf_wheel_speed = sp[15:0]; r.lf_wheel_angle = ang[k][15:0]; end
          1: begin r.lr_wheel_speed = sp[15:0]; r.lr_wheel_angle = ang[k][15:0]; end
          2: begin r.rf_wheel_speed = sp[15:0]; r.rf_wheel_angle = ang[k][15:0]; end
          default: begin r.rr_wheel_speed = sp[15:0]; r.rr_wheel_angle = ang[k][15:0]; end
        endcase
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, int expd, int act);
      if (expd != act) begin
        $error("%s: expected %0d, got %0d", name, expd, act);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("lf_wheel_speed", e.lf_wheel_speed, got.lf_wheel_speed);
      cmp("lr_wheel_speed", e.lr_wheel_speed, got.lr_wheel_speed);
      cmp("rf_wheel_speed", e.rf_wheel_speed, got.rf_wheel_speed);
      cmp("rr_wheel_speed", e.rr_wheel_speed, got.rr_wheel_speed);
      cmp("lf_wheel_angle", e.lf_wheel_angle, got.lf_wheel_angle);
      cmp("lr_wheel_angle", e.lr_wheel_angle, got.lr_wheel_angle);
      cmp("rf_wheel_angle", e.rf_wheel_angle, got.rf_wheel_angle);
      cmp("rr_wheel_angle", e.rr_wheel_angle, got.rr_wheel_angle);
      cmp("angles_valid", e.angles_valid, got.angles_valid);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  wheel_scoreboard sb;
  int              idle_pct;
  int              quiet_cycles;

  swerve_drive_wheel_kinematics u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // low phase first so the first rising edge falls clear of time zero
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result monitor and watchdog, sampling values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one command transfer, with random sender gaps ahead of it
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
  endtask

  // all offsets of one setting; written back to back, enable dropped after the last
  task automatic write_offsets(int kind);
    cfg_reg_e    r;
    logic [15:0] v;
    r = r.first();
    do begin
      case (kind)
        0: v = 16'h0000;
        1: v = r[0] ? (r[2] ? -16'sd1200 : 16'sd1200) : (r[1] ? -16'sd1000 : 16'sd1000);
        2: v = 16'h7fff;
        3: v = 16'h8000;
        4: v = r[0] ? 16'h8000 : 16'h7fff;
        default: v = ($urandom_range(0, 1) != 0) ? 16'($urandom) :
                     16'($signed($urandom_range(0, 8192)) - 4096);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= v;
      sb.set_offset(r, v);
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 46080)) - 23040);
  endfunction

  function automatic logic [15:0] rand_rate();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'h0000;
      2:       return ($urandom_range(0, 1) != 0) ? 16'sd4096 : -16'sd4096;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.drive_speed   = rand_rate();
    c.drive_heading = rand_angle();
    c.turn_rate     = rand_rate();
    c.lf_now_angle  = rand_angle();
    c.lr_now_angle  = rand_angle();
    c.rf_now_angle  = rand_angle();
    c.rr_now_angle  = rand_angle();
    // a few commands land in the deadband
    if ($urandom_range(0, 39) == 0) begin
      c.drive_speed   = '0;
      c.drive_heading = '0;
      c.turn_rate     = '0;
    end
    return c;
  endfunction

  function automatic cmd_t make_cmd(int s, int h, int w, int a);
    cmd_t c;
    c.drive_speed   = 16'(s);
    c.drive_heading = 16'(h);
    c.turn_rate     = 16'(w);
    c.lf_now_angle  = 16'(a);
    c.lr_now_angle  = 16'(-a);
    c.rf_now_angle  = 16'(a / 2);
    c.rr_now_angle  = 16'(a + 11520);
    return c;
  endfunction

  // wait for every expected result, then let the pipe drain fully
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    idle_pct     = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_offsets(1);
    // directed: deadband, field extremes, zero wheel velocity, overspeed rescale, flips
    send_cmd(make_cmd(0, 0, 0, 0));
    send_cmd(make_cmd(0, 0, 0, 23040));
    send_cmd(make_cmd(0, 0, 0, -23040));
    send_cmd(make_cmd(0, 4608, 0, 100));
    send_cmd(make_cmd(32767, 0, 0, 0));
    send_cmd(make_cmd(-32768, 0, 0, 0));
    send_cmd(make_cmd(4096, 23040, 0, 11520));
    send_cmd(make_cmd(4096, -23040, 0, -11520));
    send_cmd(make_cmd(4096, 32767, 0, 5760));
    send_cmd(make_cmd(4096, -32768, 0, -5760));
    send_cmd(make_cmd(0, 0, 32767, 0));
    send_cmd(make_cmd(0, 0, -32768, 0));
    send_cmd(make_cmd(4096, 0, 4096, 0));
    send_cmd(make_cmd(4096, 5760, -4096, 11520));
    send_cmd(make_cmd(2048, 11520, 0, 0));
    send_cmd(make_cmd(2048, 11520, 0, 11520));
    send_cmd(make_cmd(2048, -5760, 0, 5760));
    send_cmd(make_cmd(1, 0, 0, 32767));
    send_cmd(make_cmd(0, 1, 0, -32768));
    send_cmd(make_cmd(0, 0, -1, 0));
    send_cmd(make_cmd(-4096, 2880, 2048, -17280));
    drain();

    // random phases: each writes an offset setting and picks an idling pattern by phase number
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_offsets(ph == 1 ? 0 : ph);
      case (ph % 4)
        1:       idle_pct = 84;
        3:       idle_pct = 21;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_cmd(rand_cmd());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/swk_pkg.sv
rtl/core/swk_front.sv
rtl/core/swk_polar.sv
rtl/core/swk_scale.sv
rtl/core/swerve_drive_wheel_kinematics.sv
bench/tb_swerve_drive_wheel_kinematics.sv
